// File: rtl/sdsc_pkg.sv
// ----------------------------------------------------------------------------
// sdsc_pkg
// Types and constants shared by the SD SPI-mode command engine modules.
// ----------------------------------------------------------------------------
package sdsc_pkg;

    // Item operation codes
    localparam logic OP_START    = 1'b0;
    localparam logic OP_RECEIVED = 1'b1;

    // Configuration register indexes
    localparam logic CFG_BUSY_TIMEOUT     = 1'b0;
    localparam logic CFG_RESPONSE_TIMEOUT = 1'b1;

    // Response modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_R1   = 2'd1;
    localparam logic [1:0] MODE_R2   = 2'd2;
    localparam logic [1:0] MODE_R6   = 2'd3;

    // Completion status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BUSY      = 2'd1;
    localparam logic [1:0] STAT_NO_RESP   = 2'd2;

    // Fixed byte values
    localparam logic [7:0]  CMD_START_BITS = 8'h40;
    localparam logic [7:0]  CRC_CMD0       = 8'h95;
    localparam logic [7:0]  IDLE_BYTE      = 8'hFF;
    localparam logic [15:0] RESP_BUSY      = 16'hFFFF;
    localparam logic [15:0] RESP_NO_START  = 16'hFFFE;
    localparam logic [2:0]  LAST_FRAME_IDX = 3'd5;

    // Reset values of the configuration registers
    localparam logic [9:0] BUSY_TIMEOUT_RST     = 10'd50;
    localparam logic [5:0] RESPONSE_TIMEOUT_RST = 6'd6;

    // Command sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_BUSY    = 5'b00010,
        PH_FRAME   = 5'b00100,
        PH_SEARCH  = 5'b01000,
        PH_COLLECT = 5'b10000
    } t_phase;

    // Input item
    typedef struct packed {
        logic        operation;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [1:0]  response_mode;
        logic [7:0]  miso_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]  mosi_byte;
        logic        exchange;
        logic        done_res;
        logic [15:0] response;
        logic [1:0]  status;
    } t_out_item;

    // Configuration registers as seen by the core
    typedef struct packed {
        logic [9:0] busy_timeout;
        logic [5:0] response_timeout;
    } t_cfg;

endpackage

// File: rtl/sdsc_core.sv
// ----------------------------------------------------------------------------
// sdsc_core
// Command sequencer state and the combinational step logic for one item.
// ----------------------------------------------------------------------------
module sdsc_core
    import sdsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    t_phase      r_phase,         n_phase;
    logic [2:0]  r_byte_index,    n_byte_index;
    logic [9:0]  r_wait_count,    n_wait_count;
    logic [5:0]  r_held_command,  n_held_command;
    logic [31:0] r_held_argument, n_held_argument;
    logic [1:0]  r_held_mode,     n_held_mode;
    logic [15:0] r_resp_shift,    n_resp_shift;

    // Byte k of the six-byte command frame
    function automatic logic [7:0] frame_byte(input logic [5:0] cmd,
                                              input logic [31:0] arg,
                                              input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = {2'b00, cmd} | CMD_START_BITS;
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = (cmd == 6'd0) ? CRC_CMD0 : IDLE_BYTE;
        endcase
        return b;
    endfunction

    logic [2:0]  idx_inc;
    logic [2:0]  need;
    logic [15:0] shift_next;

    assign idx_inc    = r_byte_index + 3'd1;
    assign need       = (r_held_mode == MODE_R2) ? 3'd2 : 3'd6;
    assign shift_next = {r_resp_shift[7:0], i_item.miso_byte};

    // Step logic: next state and result for the item in the input register
    always_comb begin
        n_phase         = r_phase;
        n_byte_index    = r_byte_index;
        n_wait_count    = r_wait_count;
        n_held_command  = r_held_command;
        n_held_argument = r_held_argument;
        n_held_mode     = r_held_mode;
        n_resp_shift    = r_resp_shift;
        o_res           = '{mosi_byte: IDLE_BYTE, exchange: 1'b1, done_res: 1'b0,
                            response: 16'd0, status: STAT_OK};

        if (i_item.operation == OP_START) begin
            n_held_command  = i_item.command_index;
            n_held_argument = i_item.argument;
            n_held_mode     = i_item.response_mode;
            n_resp_shift    = 16'd0;
            n_byte_index    = 3'd0;
            n_wait_count    = 10'd0;
            n_phase         = PH_BUSY;
        end else begin
            case (r_phase)
                PH_BUSY: begin
                    if (i_item.miso_byte[0]) begin
                        n_phase         = PH_FRAME;
                        n_byte_index    = 3'd0;
                        o_res.mosi_byte = frame_byte(r_held_command, r_held_argument, 3'd0);
                    end else if (r_wait_count >= i_cfg.busy_timeout) begin
                        n_phase        = PH_IDLE;
                        n_byte_index   = 3'd0;
                        n_wait_count   = 10'd0;
                        o_res.exchange = 1'b0;
                        o_res.done_res = 1'b1;
                        o_res.response = RESP_BUSY;
                        o_res.status   = STAT_BUSY;
                    end else begin
                        n_wait_count = r_wait_count + 10'd1;
                    end
                end
                PH_FRAME: begin
                    if (r_byte_index < LAST_FRAME_IDX) begin
                        n_byte_index    = idx_inc;
                        o_res.mosi_byte = frame_byte(r_held_command, r_held_argument,
                                                     idx_inc);
                    end else if (r_held_mode == MODE_NONE) begin
                        n_phase        = PH_IDLE;
                        n_byte_index   = 3'd0;
                        n_wait_count   = 10'd0;
                        o_res.exchange = 1'b0;
                        o_res.done_res = 1'b1;
                    end else begin
                        n_phase      = PH_SEARCH;
                        n_wait_count = 10'd0;
                    end
                end
                PH_SEARCH: begin
                    if (!i_item.miso_byte[7]) begin
                        n_resp_shift = {8'd0, i_item.miso_byte};
                        if (r_held_mode == MODE_R1) begin
                            n_phase        = PH_IDLE;
                            n_byte_index   = 3'd0;
                            n_wait_count   = 10'd0;
                            o_res.exchange = 1'b0;
                            o_res.done_res = 1'b1;
                            o_res.response = {8'd0, i_item.miso_byte};
                        end else begin
                            n_phase      = PH_COLLECT;
                            n_byte_index = 3'd1;
                        end
                    end else if (r_wait_count >= {4'd0, i_cfg.response_timeout}) begin
                        n_phase        = PH_IDLE;
                        n_byte_index   = 3'd0;
                        n_wait_count   = 10'd0;
                        o_res.exchange = 1'b0;
                        o_res.done_res = 1'b1;
                        o_res.response = RESP_NO_START;
                        o_res.status   = STAT_NO_RESP;
                    end else begin
                        n_wait_count = r_wait_count + 10'd1;
                    end
                end
                PH_COLLECT: begin
                    n_resp_shift = shift_next;
                    n_byte_index = idx_inc;
                    if (idx_inc >= need) begin
                        n_phase        = PH_IDLE;
                        n_byte_index   = 3'd0;
                        n_wait_count   = 10'd0;
                        o_res.exchange = 1'b0;
                        o_res.done_res = 1'b1;
                        o_res.response = (r_held_mode == MODE_R2) ? shift_next
                                                                  : {8'd0, i_item.miso_byte};
                    end
                end
                default: begin
                    // received byte with no command running: ignored
                    n_phase        = PH_IDLE;
                    o_res.exchange = 1'b0;
                end
            endcase
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_byte_index    <= 3'd0;
            r_wait_count    <= 10'd0;
            r_held_command  <= 6'd0;
            r_held_argument <= 32'd0;
            r_held_mode     <= MODE_NONE;
            r_resp_shift    <= 16'd0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_byte_index    <= n_byte_index;
            r_wait_count    <= n_wait_count;
            r_held_command  <= n_held_command;
            r_held_argument <= n_held_argument;
            r_held_mode     <= n_held_mode;
            r_resp_shift    <= n_resp_shift;
        end
    end

    // A finished command leaves the sequencer idle with counters cleared
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.done_res |=> r_phase == PH_IDLE && r_wait_count == 10'd0)
        else $error("sdsc_core: completion did not return to idle");

    // A start always restarts the busy poll from zero
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.operation == OP_START |=> r_phase == PH_BUSY
            && r_wait_count == 10'd0 && r_byte_index == 3'd0)
        else $error("sdsc_core: start did not enter busy poll");

    // Frame index never runs past the CRC byte
    a_frame_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FRAME |-> r_byte_index <= LAST_FRAME_IDX)
        else $error("sdsc_core: frame index out of range");

    // Collection index stays between the first and the last response byte
    a_collect_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COLLECT |-> r_byte_index >= 3'd1 && r_byte_index <= 3'd5)
        else $error("sdsc_core: collect index out of range");

endmodule

// File: rtl/sd_spi_command_engine.sv
// An accepted item is held in the input register, and its result is registered
// in the result register before it is presented. The engine takes one item per
// cycle while the output is not stalled; each item drives at most one SPI byte exchange.
// The input register and the result register form two skid-free stages.
// Reset (synchronous, active low) empties both stages, sets the sequencer
// idle and loads the timeouts with busy 50 and response 6.
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// Host-side SD SPI-mode command engine: busy poll, command frame, response
// search and collection, at most one byte exchange per item.
// ----------------------------------------------------------------------------
module sd_spi_command_engine
    import sdsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [9:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item step_res;
    logic      fire;

    // Item in the input register moves on when the result register frees up
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.busy_timeout     <= BUSY_TIMEOUT_RST;
            r_cfg.response_timeout <= RESPONSE_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUSY_TIMEOUT:     r_cfg.busy_timeout     <= i_cfg_data;
                CFG_RESPONSE_TIMEOUT: r_cfg.response_timeout <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Step logic and sequencer state
    sdsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

endmodule
